[rtl/core/mwo_pkg.sv]
// ----------------------------------------------------------------------------
// mwo_pkg: shared types and constants for the multi-waveform oscillator
// Holds register codes, waveform codes, reset values and the quarter-wave
// sine entry function that is used to build the sine table.
// ----------------------------------------------------------------------------
package mwo_pkg;

  // Default sizes for the top-level parameters.
  localparam int PHASE_BITS_DEF       = 32;
  localparam int SAMPLE_BITS_DEF      = 16;
  localparam int SINE_TABLE_DEPTH_DEF = 256;

  // Fixed register widths.
  localparam int STEP_BITS   = 32;
  localparam int KIND_BITS   = 2;
  localparam int TOTAL_BITS  = 24;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 32;

  // Register reset values.
  localparam logic [STEP_BITS-1:0]  STEP_RESET  = 32'd97391549;
  localparam logic [TOTAL_BITS-1:0] TOTAL_RESET = 24'd44100;

  // Sine lookup geometry: two quadrant bits above a 24-bit position.
  localparam int QUARTER_BITS = 24;
  localparam int SINE_TOP_BITS = QUARTER_BITS + 2;

  // Angle of a quarter turn in Q2.30.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_WAVE_KIND    = 2'd1,
    CFG_SAMPLE_TOTAL = 2'd2
  } cfg_reg_t;

  // Waveform selection codes.
  typedef enum logic [KIND_BITS-1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_kind_t;

  // Flags of one sample descriptor handed from the phase stage onward.
  typedef struct packed {
    logic emit;   // the accepted item produces a sample
    logic last;   // final sample of the run
    logic sine;   // value comes from the sine table
    logic neg;    // table value is negated
  } mwo_desc_t;

  // Two Q2.30 multiplies by x, truncating after each.
  function automatic longint unsigned mul_x2(longint unsigned t, longint unsigned x);
    longint unsigned p;
    p = (t * x) >> 30;
    p = (p * x) >> 30;
    return p;
  endfunction

  // Quarter-wave sine entry for angle x (Q2.30), as a Q1.frac_bits value.
  // Taylor series up to the x^13 term, truncated at every step, then rounded
  // half up and saturated just below full scale.
  function automatic longint quarter_sine(longint unsigned x, int frac_bits);
    longint unsigned t;
    longint sum;
    longint full;
    longint v;
    t = x;
    sum = longint'(x);
    t = mul_x2(t, x) / 6;   sum = sum - longint'(t);
    t = mul_x2(t, x) / 20;  sum = sum + longint'(t);
    t = mul_x2(t, x) / 42;  sum = sum - longint'(t);
    t = mul_x2(t, x) / 72;  sum = sum + longint'(t);
    t = mul_x2(t, x) / 110; sum = sum - longint'(t);
    t = mul_x2(t, x) / 156; sum = sum + longint'(t);
    if (sum < 0) begin
      sum = 0;
    end
    full = longint'(1) << frac_bits;
    v = (sum * full + (longint'(1) << 29)) >>> 30;
    if (v > full - 1) begin
      v = full - 1;
    end
    return v;
  endfunction

endpackage

[rtl/core/mwo_ram.sv]
// ----------------------------------------------------------------------------
// mwo_ram: generic simple dual-port RAM
// One write port and one read port with a registered read; the read data
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module mwo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 257
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/mwo_sine_fill.sv]
// ----------------------------------------------------------------------------
// mwo_sine_fill: sine table loader
// After reset, sweeps the quarter-wave constants into the sine RAM, one
// entry per cycle, and then raises fill_done.
// ----------------------------------------------------------------------------
module mwo_sine_fill #(
  parameter int SAMPLE_BITS      = mwo_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  output logic                                  we,
  output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] waddr,
  output logic [SAMPLE_BITS-1:0]                wdata,
  output logic                                  fill_done
);

  localparam int AW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FCW = $clog2(SINE_TABLE_DEPTH + 2);

  logic [FCW-1:0]         fill_cnt_r;
  logic [FCW-1:0]         fill_cnt_nxt;
  logic [SAMPLE_BITS-1:0] rom_word [0:SINE_TABLE_DEPTH];

  // Constant quarter-wave table, one entry per angle step.
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam longint unsigned X =
      (longint'(g) * mwo_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign rom_word[g] = SAMPLE_BITS'(mwo_pkg::quarter_sine(X, SAMPLE_BITS - 1));
  end

  // Sweep control.
  assign fill_done    = (fill_cnt_r == FCW'(SINE_TABLE_DEPTH + 1));
  assign fill_cnt_nxt = fill_done ? fill_cnt_r : fill_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  // RAM write port.
  assign we    = !fill_done;
  assign waddr = fill_cnt_r[AW-1:0];
  assign wdata = rom_word[fill_cnt_r[AW-1:0]];

endmodule

[rtl/core/mwo_phase_ctrl.sv]
// ----------------------------------------------------------------------------
// mwo_phase_ctrl: phase accumulator and waveform decode
// Holds phase, sample count and run flag; for each accepted item it forms
// the sample descriptor (table address or direct value) and advances state.
// ----------------------------------------------------------------------------
module mwo_phase_ctrl #(
  parameter int PHASE_BITS       = mwo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS      = mwo_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_fire,
  input  logic                                  restart,
  input  logic [mwo_pkg::STEP_BITS-1:0]         phase_step,
  input  mwo_pkg::wave_kind_t                   wave_kind,
  input  logic [mwo_pkg::TOTAL_BITS-1:0]        sample_total,
  output mwo_pkg::mwo_desc_t                    desc,
  output logic [SAMPLE_BITS-1:0]                desc_val,
  output logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] desc_addr
);

  localparam int AW   = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QB   = mwo_pkg::QUARTER_BITS;
  localparam int TOPW = mwo_pkg::SINE_TOP_BITS;
  localparam int SB   = mwo_pkg::STEP_BITS;
  localparam int TB   = mwo_pkg::TOTAL_BITS;
  localparam int S    = SAMPLE_BITS;

  localparam logic [S-1:0]   POS_FULL = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0]   NEG_FULL = {1'b1, {(S-1){1'b0}}};
  localparam logic [S+1:0]   TRI_BASE = (S+2)'(3) << (S - 1);
  localparam logic [S+1:0]   TRI_TOP  = (S+2)'(1) << (S - 1);

  logic [PHASE_BITS-1:0]      phase_r, phase_nxt;
  logic [TB-1:0]              done_r, done_nxt;
  logic                       running_r, running_nxt;

  logic [PHASE_BITS-1:0]      ph_cur;
  logic [TB-1:0]              done_cur;
  logic                       run_cur;
  logic [TB:0]                done_inc;
  logic                       last;
  logic [PHASE_BITS+TOPW-1:0] ph_ext;
  logic [SB+PHASE_BITS-1:0]   step_ext;
  logic [PHASE_BITS-1:0]      step;
  logic [TOPW-1:0]            q_sin;
  logic [S:0]                 q_tri;
  logic [S-1:0]               q_saw;
  logic [QB+AW-1:0]           idx_prod;
  logic [AW-1:0]              idx;
  logic [S+1:0]               tri_fall;
  logic [S-1:0]               tri_val;

  // Restart clears the run before this item's sample is taken.
  assign ph_cur   = restart ? '0 : phase_r;
  assign done_cur = restart ? '0 : done_r;
  assign run_cur  = restart ? (sample_total != '0) : running_r;
  assign done_inc = {1'b0, done_cur} + 1'b1;
  assign last     = (done_inc >= {1'b0, sample_total});

  // Top phase bits, padded with zeros when the accumulator is narrow.
  assign ph_ext = {ph_cur, TOPW'(0)};
  assign q_sin  = ph_ext[PHASE_BITS+TOPW-1 -: TOPW];
  assign q_tri  = ph_ext[PHASE_BITS+TOPW-1 -: S+1];
  assign q_saw  = ph_ext[PHASE_BITS+TOPW-1 -: S];

  // Step scaled from 32 bits to the accumulator width.
  assign step_ext = {phase_step, PHASE_BITS'(0)};
  assign step     = step_ext[SB+PHASE_BITS-1 -: PHASE_BITS];

  // Sine table index from the position within the quadrant.
  assign idx_prod = {AW'(0), q_sin[QB-1:0]} * (QB+AW)'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[QB+AW-1:QB];

  // Falling half of the triangle, saturated at plus full scale.
  assign tri_fall = TRI_BASE - {1'b0, q_tri};
  assign tri_val  = (tri_fall == TRI_TOP) ? POS_FULL : tri_fall[S-1:0];

  // Descriptor for the sample of this item.
  always_comb begin
    desc.emit = in_fire && run_cur;
    desc.last = last;
    desc.sine = 1'b0;
    desc.neg  = q_sin[TOPW-1];
    desc_addr = q_sin[TOPW-2] ? AW'(SINE_TABLE_DEPTH) - idx : idx;
    desc_val  = '0;
    case (wave_kind)
      mwo_pkg::WAVE_SINE: begin
        desc.sine = 1'b1;
      end
      mwo_pkg::WAVE_SQUARE: begin
        desc_val = ph_cur[PHASE_BITS-1] ? POS_FULL : NEG_FULL;
      end
      mwo_pkg::WAVE_TRIANGLE: begin
        desc_val = q_tri[S] ? tri_val : {~q_tri[S-1], q_tri[S-2:0]};
      end
      mwo_pkg::WAVE_SAWTOOTH: begin
        desc_val = {~q_saw[S-1], q_saw[S-2:0]};
      end
      default: begin
        desc_val = '0;
      end
    endcase
  end

  // Next run state.
  always_comb begin
    phase_nxt   = phase_r;
    done_nxt    = done_r;
    running_nxt = running_r;
    if (in_fire) begin
      if (run_cur) begin
        phase_nxt   = ph_cur + step;
        done_nxt    = done_inc[TB-1:0];
        running_nxt = !last;
      end else begin
        phase_nxt   = ph_cur;
        done_nxt    = done_cur;
        running_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      done_r    <= '0;
      running_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      done_r    <= done_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

[rtl/core/multi_waveform_oscillator_core.sv]
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_core: phase-accumulator oscillator
// Sine, square, triangle and sawtooth samples in signed Q1.(SAMPLE_BITS-1)
// with run counting and a last-sample flag.
// ----------------------------------------------------------------------------
// Path: an accepted item is registered in stage one and then in the output register.
// Throughput: one item per cycle while out_tready is high; the phase add and one
// sine RAM read per sample set the pace, and an output stall backs up through stage one.
// Reset: synchronous; after reset the sine RAM is loaded with its SINE_TABLE_DEPTH+1
// entries with in_tready low, while configuration writes are still taken.
module multi_waveform_oscillator_core #(
  parameter int PHASE_BITS       = mwo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS      = mwo_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = mwo_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration write port.
  input  logic                              cfg_we,
  input  logic [mwo_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [mwo_pkg::CFG_DW-1:0]        cfg_wdata,
  // Input items.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] restart
  // Result items.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]  out_tdata,  // [SAMPLE_BITS-1:0] sample
  output logic                              out_tlast   // last_of_run
);

  localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int S     = SAMPLE_BITS;

  // Configuration registers.
  logic [mwo_pkg::STEP_BITS-1:0]  phase_step_r;
  mwo_pkg::wave_kind_t            wave_kind_r;
  logic [mwo_pkg::TOTAL_BITS-1:0] sample_total_r;

  // Pipeline signals.
  logic                in_fire;
  logic                fill_done;
  logic                fill_we;
  logic [AW-1:0]       fill_addr;
  logic [S-1:0]        fill_data;
  mwo_pkg::mwo_desc_t  desc;
  logic [S-1:0]        desc_val;
  logic [AW-1:0]       desc_addr;
  logic [S-1:0]        ram_rdata;

  logic                s1_valid_r;
  logic                s1_last_r;
  logic                s1_sine_r;
  logic                s1_neg_r;
  logic [S-1:0]        s1_val_r;
  logic                s1_ready;
  logic [S-1:0]        s1_sample;

  logic                out_valid_r;
  logic [S-1:0]        out_sample_r;
  logic                out_last_r;
  logic                out_load;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= mwo_pkg::STEP_RESET;
      wave_kind_r    <= mwo_pkg::WAVE_SINE;
      sample_total_r <= mwo_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      case (mwo_pkg::cfg_reg_t'(cfg_addr))
        mwo_pkg::CFG_PHASE_STEP: begin
          phase_step_r <= cfg_wdata[mwo_pkg::STEP_BITS-1:0];
        end
        mwo_pkg::CFG_WAVE_KIND: begin
          wave_kind_r <= mwo_pkg::wave_kind_t'(cfg_wdata[mwo_pkg::KIND_BITS-1:0]);
        end
        mwo_pkg::CFG_SAMPLE_TOTAL: begin
          sample_total_r <= cfg_wdata[mwo_pkg::TOTAL_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake and stage flow.
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_ready  = !s1_valid_r || out_load;
  assign in_tready = s1_ready && fill_done;
  assign in_fire   = in_tvalid && in_tready;

  // Sine table loader.
  mwo_sine_fill #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .we        (fill_we),
    .waddr     (fill_addr),
    .wdata     (fill_data),
    .fill_done (fill_done)
  );

  // Sine table memory.
  mwo_ram #(
    .WIDTH (S),
    .DEPTH (SINE_TABLE_DEPTH + 1)
  ) u_sine_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .re    (desc.emit),
    .raddr (desc_addr),
    .rdata (ram_rdata)
  );

  // Phase accumulator and waveform decode.
  mwo_phase_ctrl #(
    .PHASE_BITS       (PHASE_BITS),
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .restart      (in_tdata[0]),
    .phase_step   (phase_step_r),
    .wave_kind    (wave_kind_r),
    .sample_total (sample_total_r),
    .desc         (desc),
    .desc_val     (desc_val),
    .desc_addr    (desc_addr)
  );

  // Stage one waits for the table read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= desc.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (desc.emit) begin
      s1_last_r <= desc.last;
      s1_sine_r <= desc.sine;
      s1_neg_r  <= desc.neg;
      s1_val_r  <= desc_val;
    end
  end

  // Final sample: signed table value or the direct value.
  assign s1_sample = s1_sine_r ? (s1_neg_r ? -ram_rdata : ram_rdata) : s1_val_r;

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= s1_sample;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_sample_r);
  assign out_tlast  = out_last_r;

  // A restart with an empty run produces no sample.
  a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tdata[0] && (sample_total_r == '0) |=> !s1_valid_r)
    else $error("empty run produced a sample");

  // Nothing enters the pipeline while the sine table is being loaded.
  a_fill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !fill_done |-> !s1_valid_r && !out_valid_r)
    else $error("item in flight during sine table load");

  // A stalled stage-one item keeps its payload.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_ready |=> s1_valid_r && $stable(s1_val_r) && $stable(s1_last_r))
    else $error("stage one item changed while stalled");

endmodule
